>>> hw/rtl/cor_pkg.sv
// Shared types and constants for the chunked overwrite ring buffer.
// Used by cor_ctrl and chunked_overwrite_ring_buffer.
package cor_pkg;

  localparam int LEN_W = 7;
  localparam int CNT_W = 5;
  localparam int POS_W = 6;
  localparam int CMD_W = 2;
  localparam int IN_SAMPLE_W = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_CHUNK_LEN = 1'b0;
  localparam logic REG_RING_LEN  = 1'b1;

  localparam logic [LEN_W-1:0] CHUNK_LEN_RST = 7'd64;
  localparam logic [CNT_W-1:0] RING_LEN_RST  = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } cor_state_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             empty;
    logic [CNT_W-1:0] fill;
  } cor_stat_t;

endpackage

>>> hw/rtl/chunked_overwrite_ring_buffer.sv
// Chunked overwrite ring buffer: top level with stream ports and config port.
// Depends on cor_pkg, cor_store and cor_ctrl.
//
// Pushes stream in at one item per cycle while no pop is in progress. A pop
// holds off the input until its whole chunk has been read, through any output
// stall: the sequencer reads one sample a cycle from the store while the output
// is not stalled, and the store's read register is the output data register, so
// results leave at one per cycle while out_tready is high. A pop of an empty ring
// gives one result with the empty flag set and holds off the input until that
// result is loaded into the output register. A register write clears the ring
// pointers; a partial chunk is lost on clear. No clearing pass is needed after reset.
module chunked_overwrite_ring_buffer
  import cor_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int CHUNK_MAX   = 64,
  parameter int RING_MAX    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [LEN_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic [CMD_W-1:0]       in_tuser,   // [1:0] cmd
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // [15:0] sample_out, [20:16] fill_count
  output logic                   out_tuser,  // [0] empty_flag
  output logic                   out_tlast
);

  localparam int DEPTH  = CHUNK_MAX * RING_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      mem_raddr;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  cor_stat_t              stat;
  logic [15:0]            sample_out;

  cor_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHUNK_MAX   (CHUNK_MAX),
    .RING_MAX    (RING_MAX),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser),
    .sample    (SAMPLE_BITS'(in_tdata)),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .out_ready (out_tready),
    .stat      (stat)
  );

  cor_store #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign sample_out = stat.empty ? 16'd0 : 16'(mem_rdata);
  assign out_tvalid = stat.valid;
  assign out_tlast  = stat.last;
  assign out_tuser  = stat.empty;
  assign out_tdata  = {{(OUT_DATA_W - CNT_W - 16){1'b0}}, stat.fill, sample_out};

endmodule

>>> hw/rtl/cor_store.sv
// Sample store: single write port, single read port, registered read data.
// Depends on nothing; widths come from the parent.
module cor_store #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/cor_ctrl.sv
// Pointer state, command decode and pop sequencer for the ring buffer.
// Depends on cor_pkg; drives the ports of cor_store.
module cor_ctrl
  import cor_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int CHUNK_MAX   = 64,
  parameter int RING_MAX    = 16,
  parameter int ADDR_W      = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [LEN_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   mem_we,
  output logic [ADDR_W-1:0]      mem_waddr,
  output logic [SAMPLE_BITS-1:0] mem_wdata,
  output logic                   mem_re,
  output logic [ADDR_W-1:0]      mem_raddr,
  input  logic                   out_ready,
  output cor_stat_t              stat
);

  localparam logic [ADDR_W-1:0] CHUNK_STRIDE = ADDR_W'(CHUNK_MAX);

  cor_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  chunk_len_r, chunk_len_nxt;
  logic [CNT_W-1:0]  ring_len_r, ring_len_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  wpos_r, wpos_nxt;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic              pop_empty_r, pop_empty_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  cor_stat_t         stat_r, stat_nxt;

  logic [LEN_W-1:0]  len_eff;
  logic [CNT_W-1:0]  ring_eff;
  logic              acc;
  logic              room;
  logic              ld;
  logic              k_last;
  logic [CNT_W-1:0]  cnt_tmp;
  logic [CNT_W:0]    slot_w;
  logic [CNT_W-1:0]  slot;

  always_comb begin
    if (chunk_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (32'(chunk_len_r) > CHUNK_MAX) begin
      len_eff = LEN_W'(CHUNK_MAX);
    end else begin
      len_eff = chunk_len_r;
    end
    if (ring_len_r == '0) begin
      ring_eff = CNT_W'(1);
    end else if (32'(ring_len_r) > RING_MAX) begin
      ring_eff = CNT_W'(RING_MAX);
    end else begin
      ring_eff = ring_len_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign room     = !stat_r.valid || out_ready;
  assign k_last   = ((LEN_W'(k_r) + LEN_W'(1)) == len_eff);

  always_comb begin
    state_nxt     = state_r;
    chunk_len_nxt = chunk_len_r;
    ring_len_nxt  = ring_len_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    wpos_nxt      = wpos_r;
    k_nxt         = k_r;
    pop_empty_nxt = pop_empty_r;
    base_nxt      = base_r;
    stat_nxt      = stat_r;
    mem_we        = 1'b0;
    mem_waddr     = ADDR_W'(tail_r) * CHUNK_STRIDE + ADDR_W'(wpos_r);
    mem_wdata     = sample;
    mem_re        = 1'b0;
    mem_raddr     = base_r + ADDR_W'(k_r);
    ld            = 1'b0;
    cnt_tmp       = cnt_r;
    slot_w        = '0;
    slot          = '0;

    if (acc) begin
      case (cmd)
        CMD_PUSH: begin
          if (wpos_r == '0 && cnt_r >= ring_eff) begin
            cnt_tmp = ring_eff - CNT_W'(1);
          end
          mem_we = 1'b1;
          if ((LEN_W'(wpos_r) + LEN_W'(1)) >= len_eff) begin
            wpos_nxt = '0;
            tail_nxt = ((tail_r + CNT_W'(1)) == ring_eff) ? '0 : tail_r + CNT_W'(1);
            cnt_nxt  = (cnt_tmp < ring_eff) ? cnt_tmp + CNT_W'(1) : cnt_tmp;
          end else begin
            wpos_nxt = wpos_r + POS_W'(1);
            cnt_nxt  = cnt_tmp;
          end
        end
        CMD_POP: begin
          state_nxt = ST_POP;
          k_nxt     = '0;
          if (cnt_r == '0) begin
            pop_empty_nxt = 1'b1;
          end else begin
            pop_empty_nxt = 1'b0;
            cnt_nxt       = cnt_r - CNT_W'(1);
            if (tail_r >= cnt_r) begin
              slot_w = {1'b0, tail_r} - {1'b0, cnt_r};
            end else begin
              slot_w = {1'b0, tail_r} + {1'b0, ring_eff} - {1'b0, cnt_r};
            end
            slot     = slot_w[CNT_W-1:0];
            base_nxt = ADDR_W'(slot) * CHUNK_STRIDE;
          end
        end
        CMD_CLEAR: begin
          tail_nxt = '0;
          cnt_nxt  = '0;
          wpos_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    if (state_r == ST_POP && room) begin
      ld = 1'b1;
      if (pop_empty_r) begin
        stat_nxt  = '{valid: 1'b1, last: 1'b1, empty: 1'b1, fill: '0};
        state_nxt = ST_IDLE;
      end else begin
        mem_re    = 1'b1;
        stat_nxt  = '{valid: 1'b1, last: k_last, empty: 1'b0, fill: cnt_r};
        k_nxt     = k_r + POS_W'(1);
        if (k_last) begin
          state_nxt = ST_IDLE;
        end
      end
    end

    if (!ld && out_ready) begin
      stat_nxt.valid = 1'b0;
    end

    if (cfg_we) begin
      if (cfg_index == REG_CHUNK_LEN) begin
        chunk_len_nxt = cfg_wdata;
      end else begin
        ring_len_nxt = cfg_wdata[CNT_W-1:0];
      end
      tail_nxt = '0;
      cnt_nxt  = '0;
      wpos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chunk_len_r  <= CHUNK_LEN_RST;
      ring_len_r   <= RING_LEN_RST;
      tail_r       <= '0;
      cnt_r        <= '0;
      wpos_r       <= '0;
      k_r          <= '0;
      pop_empty_r  <= 1'b0;
      stat_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      chunk_len_r  <= chunk_len_nxt;
      ring_len_r   <= ring_len_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      wpos_r       <= wpos_nxt;
      k_r          <= k_nxt;
      pop_empty_r  <= pop_empty_nxt;
      stat_r       <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
  end

  assign stat = stat_r;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ring_eff)
    else $error("chunk count exceeds ring length");

  a_tail_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r < ring_eff)
    else $error("tail slot out of range");

  a_wpos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(wpos_r) < len_eff)
    else $error("write position out of range");

  a_stall_holds_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && !room) |=> (state_r == ST_POP && $stable(k_r)))
    else $error("pop sequencer advanced while output stalled");
`endif

endmodule
